// ===== hw/rtl/connection_table_first_free_unit_macros.svh =====
// Assertion macros used by the connection table RTL.
`ifndef CONNECTION_TABLE_FIRST_FREE_UNIT_MACROS_SVH
`define CONNECTION_TABLE_FIRST_FREE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define CTFF_ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
`define CTFF_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define CTFF_ASSERT_IMPLY(label, clk, rst_n, pre, post, msg)
`define CTFF_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif

`endif

// ===== hw/rtl/ctff_pkg.sv =====
`default_nettype none
package ctff_pkg;

  localparam int TABLE_ENTRIES = 32;

  localparam int OP_W     = 2;
  localparam int HANDLE_W = 16;
  localparam int KEY_W    = 31;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 5;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    key;
  } entry_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ctff_table_ram.sv =====
`default_nettype none
module ctff_table_ram #(
  parameter int DEPTH = ctff_pkg::TABLE_ENTRIES,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire ctff_pkg::entry_t wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output ctff_pkg::entry_t      rdata
);

  ctff_pkg::entry_t mem [DEPTH];
  ctff_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hw/rtl/connection_table_first_free_unit.sv =====
// Insert scans from entry 0 for the first free entry and writes it there, or answers
// ST_FULL when the table is full.
// Remove and lookup read from entry 0 and stop at the first match, or answer ST_NOMATCH.
// An unused operation code answers ST_NOMATCH without a scan. One operation is in flight at a
// time: the next word is accepted once the result word is registered, or later if
// the previous result word is still waiting at the output.
// Synchronous active-low reset clears all valid marks at once; no clearing pass is needed.
`default_nettype none
`include "connection_table_first_free_unit_macros.svh"
module connection_table_first_free_unit #(
  parameter int TABLE_ENTRIES = ctff_pkg::TABLE_ENTRIES
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // operation [1:0], conn_handle [17:2], user_key [48:18], zero [55:49]
  input  wire logic [ctff_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // status [1:0], found_handle [17:2], slot_index [22:18], zero [23]
  output logic [ctff_pkg::OUT_DATA_W-1:0]      out_tdata
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
  localparam int OUT_PAD = ctff_pkg::OUT_DATA_W - ctff_pkg::STATUS_W
                           - ctff_pkg::HANDLE_W - ctff_pkg::SLOT_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_SCAN = 4'b0100,
    S_RES  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [ctff_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [ctff_pkg::HANDLE_W-1:0] handle_r, handle_nxt;
  logic [ctff_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [IW-1:0]                 idx_r, idx_nxt;
  logic                          issue_more_r, issue_more_nxt;
  logic                          chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]                 chk_idx_r, chk_idx_nxt;
  logic [TABLE_ENTRIES-1:0]      valid_r, valid_nxt;

  logic [ctff_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [ctff_pkg::HANDLE_W-1:0] res_found_r, res_found_nxt;
  logic [ctff_pkg::SLOT_W-1:0]   res_slot_r, res_slot_nxt;

  logic                          out_tvalid_r, out_tvalid_nxt;
  logic [ctff_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic             ram_we;
  logic             ram_re;
  logic [IW-1:0]    ram_raddr;
  ctff_pkg::entry_t ram_wdata;
  ctff_pkg::entry_t ram_rdata;

  logic in_accept;
  logic hit;

  ctff_table_ram #(
    .DEPTH(TABLE_ENTRIES),
    .AW   (IW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx_r),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign ram_wdata.handle = handle_r;
  assign ram_wdata.key    = key_r;
  assign ram_raddr        = idx_r;

  always_comb begin
    if (op_r == ctff_pkg::OP_REMOVE) begin
      hit = valid_r[chk_idx_r] && (ram_rdata.handle == handle_r);
    end else begin
      hit = valid_r[chk_idx_r] && (ram_rdata.key == key_r);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    handle_nxt     = handle_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    issue_more_nxt = issue_more_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    valid_nxt      = valid_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_slot_nxt   = res_slot_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_nxt         = in_tdata[1:0];
          handle_nxt     = in_tdata[17:2];
          key_nxt        = in_tdata[48:18];
          idx_nxt        = '0;
          chk_vld_nxt    = 1'b0;
          issue_more_nxt = 1'b0;
          res_found_nxt  = '0;
          res_slot_nxt   = '0;
          if (in_tdata[1:0] == ctff_pkg::OP_INSERT) begin
            state_nxt = S_INS;
          end else if (in_tdata[1:0] == ctff_pkg::OP_REMOVE ||
                       in_tdata[1:0] == ctff_pkg::OP_LOOKUP) begin
            issue_more_nxt = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            res_status_nxt = ctff_pkg::ST_NOMATCH;
            state_nxt      = S_RES;
          end
        end
      end
      S_INS: begin
        if (!valid_r[idx_r]) begin
          ram_we           = 1'b1;
          valid_nxt[idx_r] = 1'b1;
          res_status_nxt   = ctff_pkg::ST_OK;
          res_slot_nxt     = ctff_pkg::SLOT_W'(idx_r);
          state_nxt        = S_RES;
        end else if (idx_r == LAST_IDX) begin
          res_status_nxt = ctff_pkg::ST_FULL;
          state_nxt      = S_RES;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_SCAN: begin
        ram_re      = issue_more_r;
        chk_vld_nxt = issue_more_r;
        chk_idx_nxt = idx_r;
        if (issue_more_r) begin
          issue_more_nxt = (idx_r != LAST_IDX);
          if (idx_r != LAST_IDX) begin
            idx_nxt = idx_r + IW'(1);
          end
        end
        if (chk_vld_r) begin
          if (hit) begin
            res_status_nxt = ctff_pkg::ST_OK;
            res_slot_nxt   = ctff_pkg::SLOT_W'(chk_idx_r);
            if (op_r == ctff_pkg::OP_LOOKUP) begin
              res_found_nxt = ram_rdata.handle;
            end else begin
              valid_nxt[chk_idx_r] = 1'b0;
            end
            chk_vld_nxt    = 1'b0;
            issue_more_nxt = 1'b0;
            state_nxt      = S_RES;
          end else if (chk_idx_r == LAST_IDX) begin
            res_status_nxt = ctff_pkg::ST_NOMATCH;
            chk_vld_nxt    = 1'b0;
            issue_more_nxt = 1'b0;
            state_nxt      = S_RES;
          end
        end
      end
      S_RES: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{OUT_PAD{1'b0}}, res_slot_r, res_found_r, res_status_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      issue_more_r <= 1'b0;
      chk_vld_r    <= 1'b0;
      valid_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_more_r <= issue_more_nxt;
      chk_vld_r    <= chk_vld_nxt;
      valid_r      <= valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    handle_r     <= handle_nxt;
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_slot_r   <= res_slot_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

  `CTFF_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_accept, state_r != S_IDLE,
                    "accepted word did not start an operation")
  `CTFF_ASSERT_IMPLY(a_check_only_in_scan, clk, rst_n, chk_vld_r, state_r == S_SCAN,
                     "compare pending outside of a scan")
  `CTFF_ASSERT_IMPLY(a_insert_free_entry, clk, rst_n, ram_we, !valid_r[idx_r],
                     "insert overwrote a valid entry")
  `CTFF_ASSERT_IMPLY(a_handle_zero_on_fail, clk, rst_n,
                     out_tvalid_r && out_tdata_r[1:0] != ctff_pkg::ST_OK,
                     out_tdata_r[17:2] == '0, "failed operation returned a handle")

endmodule
`default_nettype wire
